// File: sv/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Types, constants and the byte-wide CRC-8 shared by the scratchpad check
// and decode blocks.
// ----------------------------------------------------------------------------
package sspc_pkg;

	localparam int FRAME_BYTES   = 9;
	localparam int KEEP_BYTES    = FRAME_BYTES - 1;
	localparam int POS_W         = 4;
	localparam int KEEP_IDX_W    = $clog2(KEEP_BYTES);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int FRACTION_STEP = 10000 / 16;
	localparam int WHOLE_W       = 12;
	localparam int FRAC_W        = 14;
	localparam int CFG_IDX_W     = 3;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [7:0] RST_ALARM_HIGH = 8'd0;
	localparam logic [7:0] RST_ALARM_LOW  = 8'd0;
	localparam logic [7:0] RST_RESOLUTION = 8'd127;
	localparam logic [7:0] RST_RESERVED_A = 8'd255;
	localparam logic [7:0] RST_RESERVED_B = 8'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALARM_HIGH = 3'd0,
		REG_ALARM_LOW  = 3'd1,
		REG_RESOLUTION = 3'd2,
		REG_RESERVED_A = 3'd3,
		REG_RESERVED_B = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CRC        = 3'd1,
		ST_BYTE5      = 3'd2,
		ST_BYTE7      = 3'd3,
		ST_RESOLUTION = 3'd4,
		ST_BYTE2      = 3'd5,
		ST_BYTE3      = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] alarm_high;
		logic [7:0] alarm_low;
		logic [7:0] resolution;
		logic [7:0] reserved_a;
		logic [7:0] reserved_b;
	} cfg_t;

	typedef struct packed {
		logic       crc_ok;
		logic [7:0] temp_lsb;
		logic [7:0] temp_msb;
		logic [7:0] alarm_high;
		logic [7:0] alarm_low;
		logic [7:0] resolution;
		logic [7:0] reserved_a;
		logic [7:0] reserved_b;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ b[k]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: sv/sspc_front.sv
// ----------------------------------------------------------------------------
// sspc_front
// Takes scratchpad bytes, tracks the frame position and running CRC, keeps
// the bytes and pushes one frame record into the queue on the ninth byte.
// ----------------------------------------------------------------------------
module sspc_front
	import sspc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic       queue_full,
	output logic       push,
	output frame_t     push_frame
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [7:0]       bytes_q [KEEP_BYTES];

	logic             accept;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       crc_in;
	logic [7:0]       crc_next;
	logic             last;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;
	assign pos_eff    = (frame_start || pos_q >= POS_W'(FRAME_BYTES)) ? '0 : pos_q;
	assign crc_in     = (pos_eff == '0) ? 8'h00 : crc_q;
	assign crc_next   = crc8_byte(crc_in, data_byte);
	assign last       = (pos_eff == POS_W'(FRAME_BYTES - 1));
	assign push       = accept && last;

	always_comb begin
		push_frame.crc_ok     = (crc_next == 8'h00);
		push_frame.temp_lsb   = bytes_q[0];
		push_frame.temp_msb   = bytes_q[1];
		push_frame.alarm_high = bytes_q[2];
		push_frame.alarm_low  = bytes_q[3];
		push_frame.resolution = bytes_q[4];
		push_frame.reserved_a = bytes_q[5];
		push_frame.reserved_b = bytes_q[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				crc_q <= '0;
			end else begin
				pos_q <= pos_eff + POS_W'(1);
				crc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last) begin
			bytes_q[pos_eff[KEEP_IDX_W-1:0]] <= data_byte;
		end
	end

endmodule

// File: sv/sspc_queue.sv
// ----------------------------------------------------------------------------
// sspc_queue
// Short frame queue between the byte front end and the check back end.
// ----------------------------------------------------------------------------
module sspc_queue
	import sspc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output frame_t pop_frame
);

	frame_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_frame = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_frame;
		end
	end

endmodule

// File: sv/sspc_back.sv
// ----------------------------------------------------------------------------
// sspc_back
// Checks the CRC of one queued frame and its expected bytes, decodes the
// temperature and holds the result in an output register.
// ----------------------------------------------------------------------------
module sspc_back
	import sspc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               frame_avail,
	input  frame_t             frame,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         status,
	output logic               rewrite_request,
	output logic               negative,
	output logic [WHOLE_W-1:0] whole_degrees,
	output logic [FRAC_W-1:0]  fraction_ten_thousandths
);

	logic               valid_q;
	status_t            status_q;
	logic               rewrite_q;
	logic               neg_q;
	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;

	logic               load;
	status_t            st;
	logic               sign;
	logic [15:0]        raw;
	logic [15:0]        mag;
	logic [FRAC_W-1:0]  frac;
	logic               ok;

	assign load = !valid_q || !result_stall;
	assign pop  = frame_avail && load;

	always_comb begin
		priority if (!frame.crc_ok) begin
			st = ST_CRC;
		end else if (frame.reserved_a != cfg.reserved_a) begin
			st = ST_BYTE5;
		end else if (frame.reserved_b != cfg.reserved_b) begin
			st = ST_BYTE7;
		end else if (frame.resolution != cfg.resolution) begin
			st = ST_RESOLUTION;
		end else if (frame.alarm_high != cfg.alarm_high) begin
			st = ST_BYTE2;
		end else if (frame.alarm_low != cfg.alarm_low) begin
			st = ST_BYTE3;
		end else begin
			st = ST_OK;
		end
	end

	assign ok   = (st == ST_OK);
	assign raw  = {frame.temp_msb, frame.temp_lsb};
	assign sign = frame.temp_msb[7];
	assign mag  = sign ? (~raw + 16'd1) : raw;
	assign frac = FRAC_W'(mag[3:0]) * FRAC_W'(FRACTION_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= frame_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= st;
			rewrite_q <= (st == ST_RESOLUTION) || (st == ST_BYTE2) || (st == ST_BYTE3);
			neg_q     <= ok && sign;
			whole_q   <= ok ? mag[15:4] : '0;
			frac_q    <= ok ? frac : '0;
		end
	end

	assign result_valid             = valid_q;
	assign status                   = status_q;
	assign rewrite_request          = rewrite_q;
	assign negative                 = neg_q;
	assign whole_degrees            = whole_q;
	assign fraction_ten_thousandths = frac_q;

endmodule

// File: sv/sensor_scratchpad_check_decode.sv
// path: after the ninth byte's transfer, a result passes through the frame queue and
// then the output register, which it enters when the output register is free
// throughput: one byte per cycle; a frame queue of two entries lets bytes
// keep flowing while a result waits, bytes stall only when the queue is full
// reset: position, crc, queue and output valid cleared; expected values set
// to 0, 0, 127, 255, 16
// ----------------------------------------------------------------------------
// sensor_scratchpad_check_decode
// Scratchpad CRC check and temperature decode for a 1-Wire temperature
// sensor: byte front end, frame queue and check back end.
// ----------------------------------------------------------------------------
module sensor_scratchpad_check_decode
	import sspc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	input  logic                 frame_start,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [2:0]           status,
	output logic                 rewrite_request,
	output logic                 negative,
	output logic [WHOLE_W-1:0]   whole_degrees,
	output logic [FRAC_W-1:0]    fraction_ten_thousandths
);

	cfg_t   cfg_q;
	logic   queue_full;
	logic   push;
	frame_t push_frame;
	logic   pop;
	logic   not_empty;
	frame_t pop_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_high <= RST_ALARM_HIGH;
			cfg_q.alarm_low  <= RST_ALARM_LOW;
			cfg_q.resolution <= RST_RESOLUTION;
			cfg_q.reserved_a <= RST_RESERVED_A;
			cfg_q.reserved_b <= RST_RESERVED_B;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALARM_HIGH: cfg_q.alarm_high <= cfg_data;
				REG_ALARM_LOW:  cfg_q.alarm_low  <= cfg_data;
				REG_RESOLUTION: cfg_q.resolution <= cfg_data;
				REG_RESERVED_A: cfg_q.reserved_a <= cfg_data;
				REG_RESERVED_B: cfg_q.reserved_b <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sspc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.frame_start(frame_start),
		.queue_full (queue_full),
		.push       (push),
		.push_frame (push_frame)
	);

	sspc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_frame (pop_frame)
	);

	sspc_back u_back (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cfg                     (cfg_q),
		.frame_avail             (not_empty),
		.frame                   (pop_frame),
		.pop                     (pop),
		.result_valid            (result_valid),
		.result_stall            (result_stall),
		.status                  (status),
		.rewrite_request         (rewrite_request),
		.negative                (negative),
		.whole_degrees           (whole_degrees),
		.fraction_ten_thousandths(fraction_ten_thousandths)
	);

endmodule

// File: sv/sspc_checker.sv
// ----------------------------------------------------------------------------
// sspc_checker
// Port-level checks on the scratchpad check and decode results.
// ----------------------------------------------------------------------------
module sspc_checker
	import sspc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [2:0]           status,
	input logic                 rewrite_request,
	input logic                 negative,
	input logic [WHOLE_W-1:0]   whole_degrees,
	input logic [FRAC_W-1:0]    fraction_ten_thousandths
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// rewrite only for settings byte mismatches
	a_rewrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> rewrite_request == (status == ST_RESOLUTION
			|| status == ST_BYTE2 || status == ST_BYTE3))
		else $error("rewrite request does not match status");

	// failed frame gives no temperature
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> !negative && whole_degrees == '0
			&& fraction_ten_thousandths == '0)
		else $error("temperature reported on failed frame");

	// fraction stays within one degree
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> fraction_ten_thousandths <= FRAC_W'(15 * FRACTION_STEP))
		else $error("fraction out of range");

endmodule

bind sensor_scratchpad_check_decode sspc_checker u_sspc_checker (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.result_valid            (result_valid),
	.result_stall            (result_stall),
	.status                  (status),
	.rewrite_request         (rewrite_request),
	.negative                (negative),
	.whole_degrees           (whole_degrees),
	.fraction_ten_thousandths(fraction_ten_thousandths)
);

// File: verif/scratchpad_result_checker.sv
// ----------------------------------------------------------------------------
// scratchpad_result_checker
// Watches the byte, result and register ports of the scratchpad check and
// decode block. It keeps its own copy of the frame state and the register
// settings, predicts one result per complete nine-byte frame and compares
// every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
package scratchpad_model_pkg;
	import sspc_pkg::*;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

	typedef struct packed {
		status_t            st;
		logic               rewrite;
		logic               neg;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
	} decode_t;

	function automatic logic [7:0] onewire_crc_update(input logic [7:0] acc,
		input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] d;
		r = acc;
		d = b;
		repeat (8) begin
			if (r[0] ^ d[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
			d = d >> 1;
		end
		return r;
	endfunction

endpackage

module scratchpad_result_checker
	import sspc_pkg::*, scratchpad_model_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 byte_valid,
	input  logic                 byte_stall,
	input  logic [7:0]           data_byte,
	input  logic                 frame_start,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [2:0]           status,
	input  logic                 rewrite_request,
	input  logic                 negative,
	input  logic [WHOLE_W-1:0]   whole_degrees,
	input  logic [FRAC_W-1:0]    fraction_ten_thousandths,
	output int                   mismatches,
	output int                   pending,
	output int                   checked,
	output logic [7:0]           status_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t         settings;
	logic [3:0]   position;
	logic [7:0]   crc_acc;
	frame_bytes_t captured;
	decode_t      decode_q[$];

	function automatic decode_t decode_frame();
		decode_t     r;
		status_t     s;
		logic [15:0] t;
		r = '0;
		if (crc_acc != 8'd0) begin
			s = ST_CRC;
		end else if (captured[5] != settings.reserved_a) begin
			s = ST_BYTE5;
		end else if (captured[7] != settings.reserved_b) begin
			s = ST_BYTE7;
		end else if (captured[4] != settings.resolution) begin
			s = ST_RESOLUTION;
		end else if (captured[2] != settings.alarm_high) begin
			s = ST_BYTE2;
		end else if (captured[3] != settings.alarm_low) begin
			s = ST_BYTE3;
		end else begin
			s = ST_OK;
		end
		r.st = s;
		r.rewrite = (s == ST_RESOLUTION) || (s == ST_BYTE2) || (s == ST_BYTE3);
		if (s == ST_OK) begin
			t = {captured[1], captured[0]};
			r.neg = t[15];
			if (r.neg) begin
				t = -t;
			end
			r.whole = t[15:4];
			r.frac = FRAC_W'(32'(t[3:0]) * FRACTION_STEP);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		if (!arst_n) begin
			settings = '{alarm_high: RST_ALARM_HIGH, alarm_low: RST_ALARM_LOW,
				resolution: RST_RESOLUTION, reserved_a: RST_RESERVED_A,
				reserved_b: RST_RESERVED_B};
			position = '0;
			crc_acc = '0;
			captured = '0;
			decode_q.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			status_seen = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALARM_HIGH: settings.alarm_high = cfg_data;
					REG_ALARM_LOW:  settings.alarm_low = cfg_data;
					REG_RESOLUTION: settings.resolution = cfg_data;
					REG_RESERVED_A: settings.reserved_a = cfg_data;
					REG_RESERVED_B: settings.reserved_b = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				checked++;
				status_seen[status] = 1'b1;
				if (decode_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result transfer: status %0d whole %0d frac %0d",
						$time, status, whole_degrees, fraction_ten_thousandths);
				end else begin
					want = decode_q.pop_front();
					if (status !== want.st) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					end
					if (rewrite_request !== want.rewrite) begin
						mismatches++;
						$display("%0t: rewrite_request expected %0d actual %0d", $time,
							want.rewrite, rewrite_request);
					end
					if (negative !== want.neg) begin
						mismatches++;
						$display("%0t: negative expected %0d actual %0d", $time, want.neg,
							negative);
					end
					if (whole_degrees !== want.whole) begin
						mismatches++;
						$display("%0t: whole_degrees expected %0d actual %0d", $time,
							want.whole, whole_degrees);
					end
					if (fraction_ten_thousandths !== want.frac) begin
						mismatches++;
						$display("%0t: fraction_ten_thousandths expected %0d actual %0d", $time,
							want.frac, fraction_ten_thousandths);
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				if (frame_start || position >= FRAME_BYTES) begin
					position = '0;
				end
				if (position == 0) begin
					crc_acc = '0;
				end
				captured[position] = data_byte;
				crc_acc = onewire_crc_update(crc_acc, data_byte);
				position++;
				if (position == FRAME_BYTES) begin
					position = '0;
					decode_q.push_back(decode_frame());
					crc_acc = '0;
				end
			end
			pending = decode_q.size();
		end
	end

endmodule

// File: verif/sensor_scratchpad_check_decode_test.sv
// ----------------------------------------------------------------------------
// sensor_scratchpad_check_decode_test
// Drives scratchpad byte streams into the check and decode block: a few
// directed frames, then phases of random well-formed frames with injected
// faults, cut-off frames and loose bytes under several register settings,
// with random idling on both sides, a long result hold-off and a quiet
// stretch. A checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module sensor_scratchpad_check_decode_test
	import sspc_pkg::*, scratchpad_model_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT      = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int PHASES        = 6;
	localparam int QUIET_PHASE   = 2;
	localparam int HOLD_PHASE    = 3;
	localparam int LIMIT_NS      = 200000;
	localparam int UNUSED_LO     = int'(REG_RESERVED_B) + 1;
	localparam int UNUSED_HI     = (1 << CFG_IDX_W) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	logic [7:0]           data_byte = '0;
	logic                 frame_start = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [2:0]           status;
	logic                 rewrite_request;
	logic                 negative;
	logic [WHOLE_W-1:0]   whole_degrees;
	logic [FRAC_W-1:0]    fraction_ten_thousandths;

	int         mismatches;
	int         pending;
	int         checked;
	logic [7:0] status_seen;

	bit   quiet = 1'b0;
	bit   hold_go = 1'b0;
	cfg_t current;
	int   bytes_sent = 0;
	int   settings_applied = 0;

	always #1 clk = ~clk;

	sensor_scratchpad_check_decode dut (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.cfg_we                   (cfg_we),
		.cfg_index                (cfg_index),
		.cfg_data                 (cfg_data),
		.byte_valid               (byte_valid),
		.byte_stall               (byte_stall),
		.data_byte                (data_byte),
		.frame_start              (frame_start),
		.result_valid             (result_valid),
		.result_stall             (result_stall),
		.status                   (status),
		.rewrite_request          (rewrite_request),
		.negative                 (negative),
		.whole_degrees            (whole_degrees),
		.fraction_ten_thousandths (fraction_ten_thousandths)
	);

	scratchpad_result_checker result_check (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.cfg_we                   (cfg_we),
		.cfg_index                (cfg_index),
		.cfg_data                 (cfg_data),
		.byte_valid               (byte_valid),
		.byte_stall               (byte_stall),
		.data_byte                (data_byte),
		.frame_start              (frame_start),
		.result_valid             (result_valid),
		.result_stall             (result_stall),
		.status                   (status),
		.rewrite_request          (rewrite_request),
		.negative                 (negative),
		.whole_degrees            (whole_degrees),
		.fraction_ten_thousandths (fraction_ten_thousandths),
		.mismatches               (mismatches),
		.pending                  (pending),
		.checked                  (checked),
		.status_seen              (status_seen)
	);

	function automatic logic [7:0] flip_bits();
		return 8'($urandom_range(1, 255));
	endfunction

	// good frame for the given settings, then the selected faults on top
	function automatic frame_bytes_t make_frame(input cfg_t c, input logic [7:0] faults,
		input logic [15:0] temp);
		frame_bytes_t f;
		logic [7:0]   acc;
		f[0] = temp[7:0];
		f[1] = temp[15:8];
		f[2] = c.alarm_high;
		f[3] = c.alarm_low;
		f[4] = c.resolution;
		f[5] = c.reserved_a;
		f[6] = 8'($urandom);
		f[7] = c.reserved_b;
		if (faults[ST_BYTE5]) f[5] = f[5] ^ flip_bits();
		if (faults[ST_BYTE7]) f[7] = f[7] ^ flip_bits();
		if (faults[ST_RESOLUTION]) f[4] = f[4] ^ flip_bits();
		if (faults[ST_BYTE2]) f[2] = f[2] ^ flip_bits();
		if (faults[ST_BYTE3]) f[3] = f[3] ^ flip_bits();
		acc = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			acc = onewire_crc_update(acc, f[i]);
		end
		f[FRAME_BYTES-1] = acc;
		if (faults[ST_CRC]) f[FRAME_BYTES-1] = acc ^ flip_bits();
		return f;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		frame_start <= s;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
	endtask

	task automatic send_frame(input frame_bytes_t f, input logic first_start, input int count);
		for (int i = 0; i < count; i++) begin
			send_byte(f[i], (i == 0) ? first_start : 1'b0);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// only while idle: every result in and the back end drained
	task automatic apply_settings(input cfg_t c);
		byte_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_ALARM_HIGH, c.alarm_high);
		write_reg(REG_ALARM_LOW, c.alarm_low);
		write_reg(REG_RESOLUTION, c.resolution);
		write_reg(REG_RESERVED_A, c.reserved_a);
		write_reg(REG_RESERVED_B, c.reserved_b);
		write_reg(CFG_IDX_W'($urandom_range(UNUSED_LO, UNUSED_HI)), 8'($urandom));
		cfg_we <= 1'b0;
		current = c;
		settings_applied++;
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (quiet) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		cfg_t         s;
		frame_bytes_t f;
		logic [7:0]   faults;
		logic [15:0]  temp;
		int           roll;
		int           phase_start;
		current = '{alarm_high: RST_ALARM_HIGH, alarm_low: RST_ALARM_LOW,
			resolution: RST_RESOLUTION, reserved_a: RST_RESERVED_A,
			reserved_b: RST_RESERVED_B};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// restart mid-frame, most negative reading, frame begun without start
		send_frame(make_frame(current, '0, 16'h1234), 1'b1, 3);
		send_frame(make_frame(current, '0, 16'h8000), 1'b1, FRAME_BYTES);
		send_frame(make_frame(current, '0, 16'hFE6F), 1'b0, FRAME_BYTES);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				s = '0;
			end else if (p == 1) begin
				s = '1;
			end else begin
				s = cfg_t'({8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom)});
			end
			apply_settings(s);
			quiet = (p == QUIET_PHASE);
			if (p == HOLD_PHASE) hold_go = 1'b1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_ITEMS / PHASES) begin
				roll = $urandom_range(0, 99);
				if (roll < 50) begin
					faults = '0;
				end else if (roll < 85) begin
					faults = 8'(1) << $urandom_range(ST_CRC, ST_BYTE3);
				end else begin
					faults = 8'($urandom);
				end
				roll = $urandom_range(0, 9);
				if (roll == 0) begin
					temp = 16'h8000;
				end else if (roll == 1) begin
					temp = 16'h7FFF;
				end else if (roll == 2) begin
					temp = 16'hFFFF;
				end else begin
					temp = 16'($urandom);
				end
				f = make_frame(current, faults, temp);
				roll = $urandom_range(0, 99);
				if (roll < 75) begin
					send_frame(f, ($urandom_range(0, 9) != 0), FRAME_BYTES);
				end else if (roll < 88) begin
					send_frame(f, 1'b1, $urandom_range(1, FRAME_BYTES - 1));
				end else begin
					repeat ($urandom_range(1, 12)) begin
						send_byte(8'($urandom), ($urandom_range(0, 4) == 0));
					end
				end
			end
		end
		quiet = 1'b0;
		byte_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d byte transfers over %0d register settings, %0d results checked",
			bytes_sent, settings_applied, checked);
		$display("summary: status codes seen %b, one long result hold-off", status_seen);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#LIMIT_NS;
		$display("timeout with %0d results outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
